/* rtl/idcr_pkg.sv */
// ----------------------------------------------------------------------------
// idcr_pkg
// Shared types and constants for the IPv4 DF-clear / checksum rewrite block.
// ----------------------------------------------------------------------------
package idcr_pkg;

   // Fixed header byte offsets that get rewritten
   localparam int unsigned IdentHiPos = 4;
   localparam int unsigned IdentLoPos = 5;
   localparam int unsigned FlagsPos   = 6;
   localparam int unsigned CsumHiPos  = 10;
   localparam int unsigned CsumLoPos  = 11;

   // Shortest header that is buffered and emitted
   localparam int unsigned MinHeaderBytes = 20;

   // Field masks
   localparam logic [7:0] DfClearMask = 8'hbf;
   localparam logic [3:0] IhlMask     = 4'hf;

   // Checksum accumulator width (covers 30 words plus the identification)
   localparam int unsigned SumWidth = 22;

   typedef enum logic [2:0] {
      ST_HDR,    // collecting header bytes and summing them
      ST_ADDID,  // add the new identification word
      ST_FOLD,   // fold end-around carries, one per cycle
      ST_EMIT,   // header run leaves from the buffer
      ST_PASS    // payload bytes pass straight through
   } state_type;

endpackage

/* rtl/idcr_ifs.sv */
// ----------------------------------------------------------------------------
// idcr_ifs
// Valid/ready channels for packet bytes in and rewritten bytes out.
// ----------------------------------------------------------------------------
interface idcr_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  in_byte;
   logic        in_last;
   logic [15:0] new_ident;

   modport source (output valid, output in_byte, output in_last, output new_ident,
                   input ready);
   modport sink   (input valid, input in_byte, input in_last, input new_ident,
                   output ready);
endinterface

interface idcr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_packet_end;
   logic       out_run_end;

   modport source (output valid, output out_byte, output out_packet_end,
                   output out_run_end, input ready);
   modport sink   (input valid, input out_byte, input out_packet_end,
                   input out_run_end, output ready);
endinterface

/* rtl/idcr_ram.sv */
// ----------------------------------------------------------------------------
// idcr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module idcr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 60
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ipv4_df_clear_checksum_rewrite.sv */
// ----------------------------------------------------------------------------
// ipv4_df_clear_checksum_rewrite
// Clears DF, replaces the identification and rewrites the IPv4 header checksum.
// ----------------------------------------------------------------------------
// Packet bytes enter one per transfer. Header bytes (IHL*4, at least 20, at
// most MAX_HEADER_BYTES) are taken one per cycle into a buffer RAM while the
// checksum is summed a byte at a time. After the last header byte (or an early
// in_last, which zero-fills the rest) input stalls while the new
// identification is added and end-around carries are folded. The header run
// then leaves through the registered RAM read stage one byte per cycle while
// the sink is ready; input stays stalled until the run's last byte moves into
// the output register. Payload bytes after the header pass through at one per
// cycle while the sink is ready.
module ipv4_df_clear_checksum_rewrite #(
   parameter int unsigned MAX_HEADER_BYTES = 60
) (
   input logic         clock,
   input logic         reset,
   idcr_req_if.sink    req_bus,
   idcr_rsp_if.source  rsp_bus
);

   localparam int unsigned PW = $clog2(MAX_HEADER_BYTES + 1);
   localparam int unsigned AW = $clog2(MAX_HEADER_BYTES);
   localparam int unsigned SW = idcr_pkg::SumWidth;
   localparam logic [5:0]  MaxLen6 = 6'(MAX_HEADER_BYTES);
   localparam logic [5:0]  MinLen6 = 6'(idcr_pkg::MinHeaderBytes);

   idcr_pkg::state_type state_ff, state_in;

   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] hdr_len_ff, hdr_len_in;
   logic [PW-1:0] ck_len_ff, ck_len_in;
   logic [PW-1:0] fill_ff, fill_in;
   logic          last_ff, last_in;
   logic [15:0]   ident_ff, ident_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [PW-1:0] rd_idx_ff, rd_idx_in;
   logic          s1_valid_ff, s1_valid_in;
   logic [PW-1:0] s1_idx_ff, s1_idx_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_pend_ff, rsp_pend_in;
   logic          rsp_rend_ff, rsp_rend_in;

   logic          req_ready;
   logic          req_xfer;
   logic          out_free;
   logic          s1_move;
   logic          rd_issue;
   logic          s1_final;
   logic [7:0]    rd_data;
   logic [7:0]    hdr_byte;
   logic [15:0]   csum;

   logic [5:0]    ihl4;
   logic [PW-1:0] hdr_len_new;
   logic [PW-1:0] ck_len_new;
   logic [PW-1:0] cur_hdr_len;
   logic [PW-1:0] cur_ck_len;
   logic [PW-1:0] word_base;
   logic          word_used;
   logic [7:0]    in_val;
   logic [SW-1:0] addend;
   logic [PW-1:0] pos_next;
   logic          flush;

   // buffer for header bytes
   idcr_ram #(
      .WIDTH (8),
      .DEPTH (MAX_HEADER_BYTES)
   ) u_hdr_ram (
      .clock   (clock),
      .wr_en   (req_xfer && (state_ff == idcr_pkg::ST_HDR)),
      .wr_addr (pos_ff[AW-1:0]),
      .wr_data (req_bus.in_byte),
      .rd_en   (rd_issue),
      .rd_addr (rd_idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // header length decode from byte 0
   always_comb begin
      ihl4 = {req_bus.in_byte[3:0] & idcr_pkg::IhlMask, 2'b00};
      priority if (ihl4 < MinLen6) begin
         hdr_len_new = PW'(MinLen6);
      end else if (ihl4 > MaxLen6) begin
         hdr_len_new = PW'(MaxLen6);
      end else begin
         hdr_len_new = PW'(ihl4);
      end
      ck_len_new  = (ihl4 > MaxLen6) ? PW'(MaxLen6) : PW'(ihl4);
      cur_hdr_len = (pos_ff == '0) ? hdr_len_new : hdr_len_ff;
      cur_ck_len  = (pos_ff == '0) ? ck_len_new  : ck_len_ff;
   end

   // per-byte checksum contribution; identification word is added in ST_ADDID
   always_comb begin
      word_base = {pos_ff[PW-1:1], 1'b0};
      word_used = (word_base != PW'(idcr_pkg::IdentHiPos))
               && (word_base != PW'(idcr_pkg::CsumHiPos))
               && (({1'b0, word_base} + (PW+1)'(1)) < {1'b0, cur_ck_len});
      in_val = (pos_ff == PW'(idcr_pkg::FlagsPos)) ?
               (req_bus.in_byte & idcr_pkg::DfClearMask) : req_bus.in_byte;
      if (!word_used) begin
         addend = '0;
      end else if (pos_ff[0]) begin
         addend = SW'(in_val);
      end else begin
         addend = SW'({in_val, 8'h00});
      end
      pos_next = pos_ff + PW'(1);
      flush    = (pos_next == cur_hdr_len) || req_bus.in_last;
   end

   // emit pipeline: RAM read stage feeding the output register
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign s1_move  = s1_valid_ff && out_free;
   assign rd_issue = (state_ff == idcr_pkg::ST_EMIT) && (rd_idx_ff != hdr_len_ff)
                     && (!s1_valid_ff || s1_move);
   assign s1_final = (s1_idx_ff == (hdr_len_ff - PW'(1)));
   assign csum     = ~sum_ff[15:0];

   // rewrite of the byte leaving the read stage
   always_comb begin
      priority if (s1_idx_ff == PW'(idcr_pkg::IdentHiPos)) begin
         hdr_byte = ident_ff[15:8];
      end else if (s1_idx_ff == PW'(idcr_pkg::IdentLoPos)) begin
         hdr_byte = ident_ff[7:0];
      end else if (s1_idx_ff == PW'(idcr_pkg::CsumHiPos)) begin
         hdr_byte = csum[15:8];
      end else if (s1_idx_ff == PW'(idcr_pkg::CsumLoPos)) begin
         hdr_byte = csum[7:0];
      end else if (s1_idx_ff >= fill_ff) begin
         hdr_byte = 8'h00;
      end else if (s1_idx_ff == PW'(idcr_pkg::FlagsPos)) begin
         hdr_byte = rd_data & idcr_pkg::DfClearMask;
      end else begin
         hdr_byte = rd_data;
      end
   end

   // input handshake
   always_comb begin
      unique case (state_ff)
         idcr_pkg::ST_HDR:  req_ready = 1'b1;
         idcr_pkg::ST_PASS: req_ready = out_free;
         default:           req_ready = 1'b0;
      endcase
   end
   assign req_xfer = req_bus.valid && req_ready;

   // next state and datapath
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      hdr_len_in   = hdr_len_ff;
      ck_len_in    = ck_len_ff;
      fill_in      = fill_ff;
      last_in      = last_ff;
      ident_in     = ident_ff;
      sum_in       = sum_ff;
      rd_idx_in    = rd_idx_ff;
      s1_valid_in  = s1_valid_ff;
      s1_idx_in    = s1_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_pend_in  = rsp_pend_ff;
      rsp_rend_in  = rsp_rend_ff;

      unique case (state_ff)
         idcr_pkg::ST_HDR: begin
            if (req_xfer) begin
               if (pos_ff == '0) begin
                  ident_in = req_bus.new_ident;
               end
               hdr_len_in = cur_hdr_len;
               ck_len_in  = cur_ck_len;
               sum_in     = ((pos_ff == '0) ? '0 : sum_ff) + addend;
               fill_in    = pos_next;
               last_in    = req_bus.in_last;
               if (flush) begin
                  pos_in   = '0;
                  state_in = idcr_pkg::ST_ADDID;
               end else begin
                  pos_in = pos_next;
               end
            end
         end
         idcr_pkg::ST_ADDID: begin
            if (ck_len_ff > PW'(idcr_pkg::IdentLoPos)) begin
               sum_in = sum_ff + SW'(ident_ff);
            end
            state_in = idcr_pkg::ST_FOLD;
         end
         idcr_pkg::ST_FOLD: begin
            if (sum_ff[SW-1:16] != '0) begin
               sum_in = SW'(sum_ff[15:0]) + SW'(sum_ff[SW-1:16]);
            end else begin
               rd_idx_in = '0;
               state_in  = idcr_pkg::ST_EMIT;
            end
         end
         idcr_pkg::ST_EMIT: begin
            if (rd_issue) begin
               rd_idx_in   = rd_idx_ff + PW'(1);
               s1_valid_in = 1'b1;
               s1_idx_in   = rd_idx_ff;
            end else if (s1_move) begin
               s1_valid_in = 1'b0;
            end
            if (s1_move) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hdr_byte;
               rsp_rend_in  = s1_final;
               rsp_pend_in  = s1_final && last_ff;
               if (s1_final) begin
                  state_in = last_ff ? idcr_pkg::ST_HDR : idcr_pkg::ST_PASS;
               end
            end
         end
         idcr_pkg::ST_PASS: begin
            if (req_xfer) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = req_bus.in_byte;
               rsp_pend_in  = req_bus.in_last;
               rsp_rend_in  = 1'b1;
               if (req_bus.in_last) begin
                  state_in = idcr_pkg::ST_HDR;
               end
            end
         end
         default: begin
            state_in = idcr_pkg::ST_HDR;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= idcr_pkg::ST_HDR;
         pos_ff       <= '0;
         hdr_len_ff   <= '0;
         ck_len_ff    <= '0;
         sum_ff       <= '0;
         ident_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         hdr_len_ff   <= hdr_len_in;
         ck_len_ff    <= ck_len_in;
         sum_ff       <= sum_in;
         ident_ff     <= ident_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fill_ff     <= fill_in;
      last_ff     <= last_in;
      rd_idx_ff   <= rd_idx_in;
      s1_idx_ff   <= s1_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_pend_ff <= rsp_pend_in;
      rsp_rend_ff <= rsp_rend_in;
   end

   assign req_bus.ready          = req_ready;
   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.out_byte       = rsp_byte_ff;
   assign rsp_bus.out_packet_end = rsp_pend_ff;
   assign rsp_bus.out_run_end    = rsp_rend_ff;

endmodule

/* rtl/idcr_checker.sv */
// ----------------------------------------------------------------------------
// idcr_checker
// Port-level checks for the IPv4 DF-clear / checksum rewrite block.
// ----------------------------------------------------------------------------
module idcr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_packet_end,
   input logic       rsp_out_run_end
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_out_packet_end)
                                  && $stable(rsp_out_run_end))
      else $error("result payload changed while stalled");

   // mid-run header bytes block new input
   a_run_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_run_end |-> !req_ready)
      else $error("input taken while a header run is still leaving");

   // packet end only closes a run
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_packet_end |-> rsp_out_run_end)
      else $error("packet end without run end");

endmodule

bind ipv4_df_clear_checksum_rewrite idcr_checker u_idcr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_out_byte       (rsp_bus.out_byte),
   .rsp_out_packet_end (rsp_bus.out_packet_end),
   .rsp_out_run_end    (rsp_bus.out_run_end)
);
